FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/nirl_pkg.sv
package nirl_pkg;

   localparam int unsigned CODE_W    = 32;
   localparam int unsigned BAR_W     = 4;
   localparam int unsigned LED_W     = 8;
   localparam int unsigned BUTTONS   = 9;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_LEAD_LOW      = 3'd0,
      REG_LEAD_HIGH     = 3'd1,
      REG_REPEAT_LOW    = 3'd2,
      REG_REPEAT_HIGH   = 3'd3,
      REG_GAP_LIMIT     = 3'd4,
      REG_ONE_THRESHOLD = 3'd5,
      REG_PLUS_CODE     = 3'd6,
      REG_MINUS_CODE    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [7:0]        lead_low;
      logic [7:0]        lead_high;
      logic [7:0]        repeat_low;
      logic [7:0]        repeat_high;
      logic [7:0]        gap_limit;
      logic [7:0]        one_threshold;
      logic [CODE_W-1:0] plus_code;
      logic [CODE_W-1:0] minus_code;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      lead_low:      8'd201,
      lead_high:     8'd221,
      repeat_low:    8'd166,
      repeat_high:   8'd186,
      gap_limit:     8'd40,
      one_threshold: 8'd26,
      plus_code:     32'h00FF_A857,
      minus_code:    32'h00FF_E01F
   };

   typedef struct packed {
      logic [LED_W-1:0]  led_pattern;
      logic              frame_done;
      logic [CODE_W-1:0] frame_code;
      logic              button_valid;
      logic [3:0]        button_index;
      logic              repeat_seen;
      logic              frame_error;
   } result_type;

   localparam logic [CODE_W-1:0] BUTTON_CODES [BUTTONS] = '{
      32'h00FF_6897, 32'h00FF_30CF, 32'h00FF_18E7, 32'h00FF_7A85, 32'h00FF_10EF,
      32'h00FF_38C7, 32'h00FF_5AA5, 32'h00FF_42BD, 32'h00FF_4AB5
   };

   // Low n bits set; n above eight lights the whole bar.
   function automatic logic [LED_W-1:0] thermometer(input logic [3:0] n);
      logic [LED_W-1:0] pat;
      for (int k = 0; k < LED_W; k++) begin
         pat[k] = (n > 4'(k));
      end
      return pat;
   endfunction

endpackage

FILE: rtl/core/nirl_csr.sv
module nirl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [nirl_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [nirl_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [nirl_pkg::CSR_DATA_W-1:0]     prdata,
   output nirl_pkg::cfg_type                   cfg
);

   nirl_pkg::cfg_type       cfg_ff;
   nirl_pkg::cfg_type       cfg_in;
   nirl_pkg::reg_index_type index;
   logic                    write_en;

   assign index    = nirl_pkg::reg_index_type'(paddr[4:2]);
   assign write_en = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            nirl_pkg::REG_LEAD_LOW:      cfg_in.lead_low      = pwdata[7:0];
            nirl_pkg::REG_LEAD_HIGH:     cfg_in.lead_high     = pwdata[7:0];
            nirl_pkg::REG_REPEAT_LOW:    cfg_in.repeat_low    = pwdata[7:0];
            nirl_pkg::REG_REPEAT_HIGH:   cfg_in.repeat_high   = pwdata[7:0];
            nirl_pkg::REG_GAP_LIMIT:     cfg_in.gap_limit     = pwdata[7:0];
            nirl_pkg::REG_ONE_THRESHOLD: cfg_in.one_threshold = pwdata[7:0];
            nirl_pkg::REG_PLUS_CODE:     cfg_in.plus_code     = pwdata;
            nirl_pkg::REG_MINUS_CODE:    cfg_in.minus_code    = pwdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         nirl_pkg::REG_LEAD_LOW:      prdata = {24'd0, cfg_ff.lead_low};
         nirl_pkg::REG_LEAD_HIGH:     prdata = {24'd0, cfg_ff.lead_high};
         nirl_pkg::REG_REPEAT_LOW:    prdata = {24'd0, cfg_ff.repeat_low};
         nirl_pkg::REG_REPEAT_HIGH:   prdata = {24'd0, cfg_ff.repeat_high};
         nirl_pkg::REG_GAP_LIMIT:     prdata = {24'd0, cfg_ff.gap_limit};
         nirl_pkg::REG_ONE_THRESHOLD: prdata = {24'd0, cfg_ff.one_threshold};
         nirl_pkg::REG_PLUS_CODE:     prdata = cfg_ff.plus_code;
         nirl_pkg::REG_MINUS_CODE:    prdata = cfg_ff.minus_code;
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= nirl_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/nirl_decode.sv
module nirl_decode #(
   parameter int unsigned FRAME_BITS = 32,
   parameter int unsigned BAR_MAX    = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           interval,
   input  logic                 overflow,
   input  nirl_pkg::cfg_type    cfg,
   output nirl_pkg::result_type result
);

   localparam int unsigned BITS_W = $clog2(FRAME_BITS + 1);

   logic [BITS_W-1:0]                 bits_ff, bits_in;
   logic [nirl_pkg::CODE_W-1:0]       shift_ff, shift_in;
   logic [nirl_pkg::BAR_W-1:0]        bar_ff, bar_in;
   logic [nirl_pkg::LED_W-1:0]        port_ff, port_in;

   logic                              idle;
   logic                              lead_hit;
   logic                              repeat_hit;
   logic [nirl_pkg::CODE_W-1:0]       shifted;
   logic                              match_any;
   logic [3:0]                        match_idx;

   assign idle       = (bits_ff >= BITS_W'(FRAME_BITS));
   assign lead_hit   = (interval > cfg.lead_low) && (interval < cfg.lead_high) && !overflow;
   assign repeat_hit = (interval > cfg.repeat_low) && (interval < cfg.repeat_high)
                       && !overflow;
   assign shifted    = {shift_ff[nirl_pkg::CODE_W-2:0], (interval > cfg.one_threshold)};

   // First button in table order wins.
   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      for (int i = nirl_pkg::BUTTONS - 1; i >= 0; i--) begin
         if (nirl_pkg::BUTTON_CODES[i] == shifted) begin
            match_any = 1'b1;
            match_idx = 4'(i);
         end
      end
   end

   always_comb begin
      bits_in  = bits_ff;
      shift_in = shift_ff;
      bar_in   = bar_ff;
      port_in  = port_ff;
      result   = '0;
      if (idle) begin
         if (lead_hit) begin
            shift_in = '0;
            bits_in  = '0;
         end else if (repeat_hit) begin
            result.repeat_seen = 1'b1;
         end
      end else if ((interval > cfg.gap_limit) || overflow) begin
         bits_in            = BITS_W'(FRAME_BITS);
         result.frame_error = 1'b1;
      end else begin
         shift_in = shifted;
         bits_in  = bits_ff + 1'b1;
         if (bits_ff == BITS_W'(FRAME_BITS - 1)) begin
            result.frame_done = 1'b1;
            if (shifted == cfg.plus_code) begin
               if (bar_ff < nirl_pkg::BAR_W'(BAR_MAX)) begin
                  bar_in = bar_ff + 1'b1;
               end
            end else if (shifted == cfg.minus_code) begin
               if (bar_ff != '0) begin
                  bar_in = bar_ff - 1'b1;
               end
            end
            if (match_any) begin
               result.button_valid = 1'b1;
               result.button_index = match_idx;
               port_in             = nirl_pkg::thermometer(match_idx);
            end else begin
               port_in = nirl_pkg::thermometer(bar_in);
            end
         end
      end
      result.led_pattern = port_in;
      result.frame_code  = shift_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= BITS_W'(FRAME_BITS);
         shift_ff <= '0;
         bar_ff   <= '0;
         port_ff  <= '0;
      end else if (advance) begin
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
         bar_ff   <= bar_in;
         port_ff  <= port_in;
      end
   end

endmodule

FILE: rtl/core/nec_ir_frame_decoder_led_bar_unit.sv
// Channel   | Direction | Handshake             | Payload
// req       | in        | req_valid / req_stall | req_interval, req_overflow
// rsp       | out       | rsp_valid / rsp_stall | led, frame, button, repeat, error flags
// csr       | in        | csr_psel / csr_penable| eight registers at byte address 4*i
//
// One transaction per edge is taken every cycle while req_stall is low; a result is
// presented once its request has passed the input register, then the result register.
// The decode step is a single compare-and-shift between those two registers.
// Reset is synchronous and active high; it restores the register defaults
// and returns the decoder to idle with an empty shift register and bar.
// A stalled result holds in its register while one more request waits in
// the input register; only then does req_stall rise.
`include "assert_macros.svh"

module nec_ir_frame_decoder_led_bar_unit #(
   parameter int unsigned FRAME_BITS = 32,
   parameter int unsigned BAR_MAX    = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_interval,
   input  logic                                req_overflow,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_led_pattern,
   output logic                                rsp_frame_done,
   output logic [31:0]                         rsp_frame_code,
   output logic                                rsp_button_valid,
   output logic [3:0]                          rsp_button_index,
   output logic                                rsp_repeat_seen,
   output logic                                rsp_frame_error,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nirl_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [nirl_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [nirl_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   // input register
   logic                 req_valid_ff, req_valid_in;
   logic [7:0]           interval_ff;
   logic                 overflow_ff;
   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   nirl_pkg::result_type rsp_ff;

   nirl_pkg::cfg_type    cfg;
   nirl_pkg::result_type step;
   logic                 out_free;
   logic                 advance;
   logic                 req_accept;

   assign csr_pready = 1'b1;

   nirl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // Result register can take a new transaction when empty or being drained.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = req_valid_ff && out_free;
   assign req_stall  = req_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   nirl_decode #(
      .FRAME_BITS (FRAME_BITS),
      .BAR_MAX    (BAR_MAX)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .interval (interval_ff),
      .overflow (overflow_ff),
      .cfg      (cfg),
      .result   (step)
   );

   always_comb begin
      // Fill on accept, drop once the step has moved into the result register.
      if (req_accept) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
      // Hold a stalled result, drop a taken one.
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         interval_ff <= req_interval;
         overflow_ff <= req_overflow;
      end
      if (advance) begin
         rsp_ff <= step;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_led_pattern  = rsp_ff.led_pattern;
   assign rsp_frame_done   = rsp_ff.frame_done;
   assign rsp_frame_code   = rsp_ff.frame_code;
   assign rsp_button_valid = rsp_ff.button_valid;
   assign rsp_button_index = rsp_ff.button_index;
   assign rsp_repeat_seen  = rsp_ff.repeat_seen;
   assign rsp_frame_error  = rsp_ff.frame_error;

   // A completed frame and an abort are exclusive outcomes of one edge.
   `ASSERT_SAME(a_done_vs_error, clock, reset, rsp_valid_ff,
      !(rsp_ff.frame_done && rsp_ff.frame_error), "frame_done and frame_error together")
   // A button match only exists on a completed frame.
   `ASSERT_SAME(a_button_needs_done, clock, reset, rsp_valid_ff && rsp_ff.button_valid,
      rsp_ff.frame_done, "button_valid without frame_done")
   // Repeat codes are only seen while idle, never on a frame edge.
   `ASSERT_SAME(a_repeat_alone, clock, reset, rsp_valid_ff && rsp_ff.repeat_seen,
      !rsp_ff.frame_done && !rsp_ff.frame_error, "repeat_seen mixed with frame flags")
   // A step that leaves the input register always lands as a valid result.
   `ASSERT_NEXT(a_advance_lands, clock, reset, advance, rsp_valid_ff, "advanced step lost")

endmodule
